// File: hdl/lnw_pkg.sv
// Shared types, codes and constants for the LCD 4-bit nibble writer.
package lnw_pkg;

  // Default geometry of the display.
  localparam int unsigned LINE_LENGTH_DEF = 20;
  localparam int unsigned ROW_COUNT_DEF   = 4;

  // Request operation codes.
  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_POS   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_GLYPH = 2'd3;

  // Port byte fields.
  localparam logic [7:0] DATA_FLAG = 8'h08;
  localparam logic [7:0] BUTTONS   = 8'h07;
  localparam logic [7:0] HI_MASK   = 8'hF0;

  // Display command values.
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] CMD_DDRAM    = 8'h80;
  localparam logic [7:0] ROW_ODD_BASE = 8'h40;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_DISPLAY  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_FUNCSET  = 8'h28;
  localparam logic [7:0] INIT_WAKE    = 8'h30;
  localparam logic [7:0] INIT_FOUR    = 8'h20;

  // Word count of the init sequence.
  localparam logic [3:0] INIT_LEN = 4'd6;

  // Work classes that the front hands to the back.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CHAR,
    KIND_POS,
    KIND_CLEAR,
    KIND_GLYPH,
    KIND_BAD
  } kind_e;

  // One classified request.
  typedef struct packed {
    logic       init;
    kind_e      kind;
    logic [7:0] value;
  } cmd_t;

  // Init sequence word for a step from 0 to 5.
  function automatic logic [7:0] init_word(input logic [2:0] step);
    logic [7:0] w;
    case (step)
      3'd0, 3'd1, 3'd2: w = INIT_WAKE | BUTTONS;
      3'd3:             w = INIT_FOUR | BUTTONS;
      3'd4:             w = (CMD_FUNCSET & HI_MASK) | BUTTONS;
      default:          w = ((CMD_FUNCSET << 4) & HI_MASK) | BUTTONS;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/lnw_front.sv
// Front end: accepts requests, tracks init state and classifies each request.
module lnw_front import lnw_pkg::*; #(
  parameter int unsigned LineLength = LINE_LENGTH_DEF,
  parameter int unsigned RowCount   = ROW_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] char_code_i,
  input  logic [2:0] row_i,
  input  logic [4:0] column_i,
  input  logic [2:0] glyph_index_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam logic [2:0] RowMax  = 3'(RowCount);
  localparam logic [5:0] ColMax  = 6'(LineLength);
  localparam logic [7:0] LineLen = 8'(LineLength);

  logic       ready_d, ready_q;
  logic       accept;
  logic       row_ok, col_ok;
  logic [7:0] row_base;
  kind_e      kind;
  logic [7:0] value;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Position checks and the display address of the target cell.
  assign row_ok = (row_i != 3'd0) && (row_i <= RowMax);
  assign col_ok = (column_i != 5'd0) && ({1'b0, column_i} <= ColMax);

  always_comb begin
    row_base = 8'h00;
    if (row_i == 3'd2 || row_i == 3'd4) row_base = row_base + ROW_ODD_BASE;
    if (row_i == 3'd3 || row_i == 3'd4) row_base = row_base + LineLen;
  end

  // Classify the request into the work the back end has to do.
  always_comb begin
    kind  = KIND_NONE;
    value = 8'h00;
    unique case (operation_i)
      OP_CHAR: begin
        kind  = KIND_CHAR;
        value = (char_code_i == 8'h00) ? SPACE_CHAR : char_code_i;
      end
      OP_POS: begin
        if (row_ok && col_ok) begin
          kind  = KIND_POS;
          value = CMD_DDRAM + row_base + {3'b000, column_i} - 8'd1;
        end else if (row_i != 3'd0 && column_i != 5'd0) begin
          kind = KIND_BAD;
        end
      end
      OP_CLEAR: kind = KIND_CLEAR;
      OP_GLYPH: begin
        kind  = KIND_GLYPH;
        value = {2'b01, glyph_index_i, 3'b000};
      end
      default: kind = KIND_NONE;
    endcase
  end

  assign cmd_o.init  = !ready_q;
  assign cmd_o.kind  = kind;
  assign cmd_o.value = value;

  // A request that causes no word is accepted and dropped.
  assign push_o = accept && (kind != KIND_NONE || !ready_q);

  // Init goes out once, ahead of the first request after reset.
  assign ready_d = ready_q || accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
    end else begin
      ready_q <= ready_d;
    end
  end

endmodule

// File: hdl/lnw_queue.sv
// Two-entry queue of classified requests between front and back.
module lnw_queue import lnw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_d, wr_ptr_q;
  logic       rd_ptr_d, rd_ptr_q;
  logic [1:0] count_d, count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
      count_d  = count_d + 2'd1;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
      count_d  = count_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: hdl/lnw_back.sv
// Back end: expands one classified request into port words, one per cycle while out_ready_i does not hold the output.
module lnw_back import lnw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] port_byte_o,
  output logic       bad_request_o,
  output logic       last_o
);

  logic [3:0] step_d, step_q;
  logic       valid_d, valid_q;
  logic [7:0] byte_d, byte_q;
  logic       bad_d, bad_q;
  logic       last_d, last_q;
  logic       emit;
  logic [3:0] body_len, total_len;
  logic [3:0] body_step;
  logic [7:0] pair_src, flag;
  logic [7:0] word;

  // Word counts of this request.
  always_comb begin
    case (head_i.kind)
      KIND_CHAR, KIND_POS, KIND_GLYPH: body_len = 4'd2;
      KIND_CLEAR:                      body_len = 4'd6;
      KIND_BAD:                        body_len = 4'd1;
      default:                         body_len = 4'd0;
    endcase
  end

  assign total_len = body_len + (head_i.init ? INIT_LEN : 4'd0);
  assign body_step = step_q - (head_i.init ? INIT_LEN : 4'd0);

  // Source byte and flag of the nibble pair being sent.
  always_comb begin
    flag     = 8'h00;
    pair_src = head_i.value;
    case (head_i.kind)
      KIND_CHAR: flag = DATA_FLAG;
      KIND_CLEAR: begin
        case (body_step[2:1])
          2'd0:    pair_src = CMD_CLEAR;
          2'd1:    pair_src = CMD_DISPLAY;
          default: pair_src = CMD_ENTRY;
        endcase
      end
      default: flag = 8'h00;
    endcase
  end

  // Word for the current step.
  always_comb begin
    if (head_i.init && step_q < INIT_LEN) begin
      word = init_word(step_q[2:0]);
    end else if (head_i.kind == KIND_BAD) begin
      word = 8'h00;
    end else if (head_i.kind == KIND_GLYPH) begin
      word = body_step[0] ? ((pair_src << 4) & HI_MASK) : (pair_src & HI_MASK);
    end else begin
      word = (body_step[0] ? ((pair_src << 4) & HI_MASK) : (pair_src & HI_MASK))
             | BUTTONS | flag;
    end
  end

  // The output register takes a new word whenever the queue is not empty and it is free or being drained.
  assign emit  = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = emit && last_d;

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q && !out_ready_i;
    byte_d  = byte_q;
    bad_d   = bad_q;
    last_d  = (step_q == total_len - 4'd1);
    if (emit) begin
      valid_d = 1'b1;
      byte_d  = word;
      bad_d   = (head_i.kind == KIND_BAD) && !(head_i.init && step_q < INIT_LEN);
      step_d  = last_d ? 4'd0 : step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 4'd0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= byte_d;
      bad_q  <= bad_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign port_byte_o   = byte_q;
  assign bad_request_o = bad_q;
  assign last_o        = last_q;

endmodule

// File: hdl/lcd_four_bit_nibble_writer_top.sv
// With the back end idle, the first word of a request passes through the queue entry and then the output register.
// The back end sends one word per cycle while out_ready_i does not hold the output register;
// a request has 2 words for a character, position or glyph request, 6 for a clear, 1 for
// an error, plus 6 init words on the first request after reset.
// Reset clears the init flag, the two-entry request queue and the output register;
// init is sent again ahead of the first request after every reset.
module lcd_four_bit_nibble_writer_top import lnw_pkg::*; #(
  parameter int unsigned LineLength = LINE_LENGTH_DEF,
  parameter int unsigned RowCount   = ROW_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] char_code_i,
  input  logic [2:0] row_i,
  input  logic [4:0] column_i,
  input  logic [2:0] glyph_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] port_byte_o,
  output logic       bad_request_o,
  output logic       last_o
);

  logic push, full, pop, empty;
  cmd_t cmd, head;

  // Request classification.
  lnw_front #(
    .LineLength(LineLength),
    .RowCount  (RowCount)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .char_code_i  (char_code_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .glyph_index_i(glyph_index_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  // Decoupling queue.
  lnw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head)
  );

  // Word sequencer.
  lnw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .port_byte_o  (port_byte_o),
    .bad_request_o(bad_request_o),
    .last_o       (last_o)
  );

endmodule
